// File: hw/rtl/rvic_pkg.sv
// rvic_pkg: shared codes and types for the RV32 instruction classifier.
// Opcode, class, error and operation codes, plus the decoded result struct.
// No dependencies.
`timescale 1ns / 1ps

package rvic_pkg;

   // Major opcodes (instruction bits 6:0)
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_AMO    = 7'b0101111;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_FENCE  = 7'b0001111;

   // Instruction classes
   localparam logic [3:0] CL_LOAD   = 4'd0;
   localparam logic [3:0] CL_STORE  = 4'd1;
   localparam logic [3:0] CL_BRANCH = 4'd2;
   localparam logic [3:0] CL_JUMP   = 4'd3;
   localparam logic [3:0] CL_AMO    = 4'd4;
   localparam logic [3:0] CL_OPIMM  = 4'd5;
   localparam logic [3:0] CL_OP     = 4'd6;
   localparam logic [3:0] CL_SYSTEM = 4'd7;
   localparam logic [3:0] CL_UPPER  = 4'd8;
   localparam logic [3:0] CL_FENCE  = 4'd9;
   localparam logic [3:0] CL_LAST   = CL_FENCE;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_OPCODE = 2'd1;
   localparam logic [1:0] ERR_SUBFN  = 2'd2;

   // funct3 values shared by several classes
   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;
   localparam logic [2:0] F3_6 = 3'd6;
   localparam logic [2:0] F3_7 = 3'd7;

   // AMO funct5 (funct7 bits 6:2)
   localparam logic [4:0] AMO_LR   = 5'h02;
   localparam logic [4:0] AMO_SC   = 5'h03;
   localparam logic [4:0] AMO_SWAP = 5'h01;
   localparam logic [4:0] AMO_ADD  = 5'h00;
   localparam logic [4:0] AMO_XOR  = 5'h04;
   localparam logic [4:0] AMO_AND  = 5'h0C;
   localparam logic [4:0] AMO_OR   = 5'h08;
   localparam logic [4:0] AMO_MIN  = 5'h10;
   localparam logic [4:0] AMO_MAX  = 5'h14;
   localparam logic [4:0] AMO_MINU = 5'h18;
   localparam logic [4:0] AMO_MAXU = 5'h1C;

   // Privileged immediates and funct7 patterns
   localparam logic [11:0] IMM_ECALL  = 12'h000;
   localparam logic [11:0] IMM_EBREAK = 12'h001;
   localparam logic [11:0] IMM_SRET   = 12'h102;
   localparam logic [11:0] IMM_WFI    = 12'h105;
   localparam logic [6:0]  F7_SFENCE_VMA = 7'h09;
   localparam logic [6:0]  F7_SINVAL_VMA = 7'h0B;
   localparam logic [6:0]  F7_SFENCE_INV = 7'h0C;
   localparam logic [6:0]  F7_ZERO       = 7'h00;

   // Operation codes
   localparam logic [6:0] OP_LB = 7'd0, OP_LH = 7'd1, OP_LW = 7'd2, OP_LBU = 7'd3,
                          OP_LHU = 7'd4;
   localparam logic [6:0] OP_SB = 7'd5, OP_SH = 7'd6, OP_SW = 7'd7;
   localparam logic [6:0] OP_BEQ = 7'd8, OP_BNE = 7'd9, OP_BLT = 7'd10, OP_BGE = 7'd11,
                          OP_BLTU = 7'd12, OP_BGEU = 7'd13;
   localparam logic [6:0] OP_JALR = 7'd14, OP_JAL = 7'd15;
   localparam logic [6:0] OP_LR = 7'd16, OP_SC = 7'd17, OP_AMOSWAP = 7'd18,
                          OP_AMOADD = 7'd19, OP_AMOXOR = 7'd20, OP_AMOAND = 7'd21,
                          OP_AMOOR = 7'd22, OP_AMOMIN = 7'd23, OP_AMOMAX = 7'd24,
                          OP_AMOMINU = 7'd25, OP_AMOMAXU = 7'd26;
   localparam logic [6:0] OP_ADDI = 7'd27, OP_SLTI = 7'd28, OP_SLTIU = 7'd29,
                          OP_XORI = 7'd30, OP_ORI = 7'd31, OP_ANDI = 7'd32,
                          OP_SLLI = 7'd33, OP_SRLI = 7'd34, OP_SRAI = 7'd35;
   localparam logic [6:0] OP_ADD = 7'd36, OP_SUB = 7'd37, OP_SLL = 7'd38, OP_SLT = 7'd39,
                          OP_SLTU = 7'd40, OP_XOR = 7'd41, OP_SRL = 7'd42,
                          OP_SRA = 7'd43, OP_OR = 7'd44, OP_AND = 7'd45;
   localparam logic [6:0] OP_MUL = 7'd46;
   localparam logic [6:0] OP_ECALL = 7'd54, OP_EBREAK = 7'd55, OP_SRET = 7'd56,
                          OP_WFI = 7'd57, OP_SFENCE_VMA = 7'd58, OP_SINVAL_VMA = 7'd59,
                          OP_SFENCE_W_INVAL = 7'd60, OP_SFENCE_INVAL_IR = 7'd61;
   localparam logic [6:0] OP_CSRRW = 7'd62, OP_CSRRS = 7'd63, OP_CSRRC = 7'd64,
                          OP_CSRRWI = 7'd65, OP_CSRRSI = 7'd66, OP_CSRRCI = 7'd67;
   localparam logic [6:0] OP_LUI = 7'd68, OP_AUIPC = 7'd69, OP_MEM_FENCE = 7'd70,
                          OP_INSTR_FENCE = 7'd71;
   localparam logic [6:0] OP_NONE = 7'd0;

   // Decoded result of one instruction
   typedef struct packed {
      logic [3:0] instr_class;
      logic [6:0] operation;
      logic [1:0] decode_error;
   } decode_type;

endpackage

// File: hw/rtl/rv32_instruction_classifier_top.sv
// Each accepted request beat passes the input reg, then the result reg, to its response.
// Throughput: one instruction per cycle unless stalled; decode is one combinational pass.
// Under backpressure both stages hold; a request beat then enters only an empty input reg.
// Reset (synchronous, active high) empties both stages; no other state is kept.
// rv32_instruction_classifier_top: RV32IMA instruction word to class / operation / error.
// Depends on rvic_pkg.
`timescale 1ns / 1ps

module rv32_instruction_classifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_instr_class,
   output logic [6:0]  rsp_operation,
   output logic [1:0]  rsp_decode_error
);

   logic                    req_valid_ff, req_valid_in;
   logic [31:0]             instr_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rvic_pkg::decode_type    result_ff, result_in;
   logic                    stage2_ready;

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [4:0]  rs2;
   logic [6:0]  f7;
   logic [11:0] imm;

   // Handshake: each stage may load when it is empty or its beat moves on
   assign stage2_ready = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !req_valid_ff || stage2_ready;
   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = stage2_ready ? req_valid_ff : rsp_valid_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture the instruction, then the decoded result
   always_ff @(posedge clock) begin
      if (req_ready) begin
         instr_ff <= req_instruction_word;
      end
      if (stage2_ready) begin
         result_ff <= result_in;
      end
   end

   // Split the instruction into fields
   assign opc = instr_ff[6:0];
   assign f3  = instr_ff[14:12];
   assign rs2 = instr_ff[24:20];
   assign f7  = instr_ff[31:25];
   assign imm = instr_ff[31:20];

   // Decode class and operation; unmatched sub-functions leave OP_NONE and flag
   always_comb begin
      result_in.instr_class  = rvic_pkg::CL_LOAD;
      result_in.operation    = rvic_pkg::OP_NONE;
      result_in.decode_error = rvic_pkg::ERR_SUBFN;
      unique case (opc)
         rvic_pkg::OPC_LOAD: begin
            result_in.instr_class = rvic_pkg::CL_LOAD;
            unique case (f3)
               rvic_pkg::F3_0: result_in.operation = rvic_pkg::OP_LB;
               rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_LH;
               rvic_pkg::F3_2: result_in.operation = rvic_pkg::OP_LW;
               rvic_pkg::F3_4: result_in.operation = rvic_pkg::OP_LBU;
               rvic_pkg::F3_5: result_in.operation = rvic_pkg::OP_LHU;
               default:        result_in.operation = rvic_pkg::OP_NONE;
            endcase
            if (f3 != rvic_pkg::F3_3 && f3 != rvic_pkg::F3_6 && f3 != rvic_pkg::F3_7) begin
               result_in.decode_error = rvic_pkg::ERR_NONE;
            end
         end
         rvic_pkg::OPC_STORE: begin
            result_in.instr_class = rvic_pkg::CL_STORE;
            unique case (f3)
               rvic_pkg::F3_0: result_in.operation = rvic_pkg::OP_SB;
               rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_SH;
               rvic_pkg::F3_2: result_in.operation = rvic_pkg::OP_SW;
               default:        result_in.operation = rvic_pkg::OP_NONE;
            endcase
            if (f3 == rvic_pkg::F3_0 || f3 == rvic_pkg::F3_1 || f3 == rvic_pkg::F3_2) begin
               result_in.decode_error = rvic_pkg::ERR_NONE;
            end
         end
         rvic_pkg::OPC_BRANCH: begin
            result_in.instr_class = rvic_pkg::CL_BRANCH;
            unique case (f3)
               rvic_pkg::F3_0: result_in.operation = rvic_pkg::OP_BEQ;
               rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_BNE;
               rvic_pkg::F3_4: result_in.operation = rvic_pkg::OP_BLT;
               rvic_pkg::F3_5: result_in.operation = rvic_pkg::OP_BGE;
               rvic_pkg::F3_6: result_in.operation = rvic_pkg::OP_BLTU;
               rvic_pkg::F3_7: result_in.operation = rvic_pkg::OP_BGEU;
               default:        result_in.operation = rvic_pkg::OP_NONE;
            endcase
            if (f3 != rvic_pkg::F3_2 && f3 != rvic_pkg::F3_3) begin
               result_in.decode_error = rvic_pkg::ERR_NONE;
            end
         end
         rvic_pkg::OPC_JALR: begin
            result_in.instr_class  = rvic_pkg::CL_JUMP;
            result_in.operation    = rvic_pkg::OP_JALR;
            result_in.decode_error = rvic_pkg::ERR_NONE;
         end
         rvic_pkg::OPC_JAL: begin
            result_in.instr_class  = rvic_pkg::CL_JUMP;
            result_in.operation    = rvic_pkg::OP_JAL;
            result_in.decode_error = rvic_pkg::ERR_NONE;
         end
         rvic_pkg::OPC_AMO: begin
            // funct3 is not examined for atomics
            result_in.instr_class  = rvic_pkg::CL_AMO;
            result_in.decode_error = rvic_pkg::ERR_NONE;
            unique case (f7[6:2])
               rvic_pkg::AMO_LR:   result_in.operation = rvic_pkg::OP_LR;
               rvic_pkg::AMO_SC:   result_in.operation = rvic_pkg::OP_SC;
               rvic_pkg::AMO_SWAP: result_in.operation = rvic_pkg::OP_AMOSWAP;
               rvic_pkg::AMO_ADD:  result_in.operation = rvic_pkg::OP_AMOADD;
               rvic_pkg::AMO_XOR:  result_in.operation = rvic_pkg::OP_AMOXOR;
               rvic_pkg::AMO_AND:  result_in.operation = rvic_pkg::OP_AMOAND;
               rvic_pkg::AMO_OR:   result_in.operation = rvic_pkg::OP_AMOOR;
               rvic_pkg::AMO_MIN:  result_in.operation = rvic_pkg::OP_AMOMIN;
               rvic_pkg::AMO_MAX:  result_in.operation = rvic_pkg::OP_AMOMAX;
               rvic_pkg::AMO_MINU: result_in.operation = rvic_pkg::OP_AMOMINU;
               rvic_pkg::AMO_MAXU: result_in.operation = rvic_pkg::OP_AMOMAXU;
               default: begin
                  result_in.operation    = rvic_pkg::OP_NONE;
                  result_in.decode_error = rvic_pkg::ERR_SUBFN;
               end
            endcase
         end
         rvic_pkg::OPC_OPIMM: begin
            // every funct3 decodes; SRLI needs funct7 zero, else SRAI
            result_in.instr_class  = rvic_pkg::CL_OPIMM;
            result_in.decode_error = rvic_pkg::ERR_NONE;
            unique case (f3)
               rvic_pkg::F3_0: result_in.operation = rvic_pkg::OP_ADDI;
               rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_SLLI;
               rvic_pkg::F3_2: result_in.operation = rvic_pkg::OP_SLTI;
               rvic_pkg::F3_3: result_in.operation = rvic_pkg::OP_SLTIU;
               rvic_pkg::F3_4: result_in.operation = rvic_pkg::OP_XORI;
               rvic_pkg::F3_5: result_in.operation = (f7 == rvic_pkg::F7_ZERO) ?
                                  rvic_pkg::OP_SRLI : rvic_pkg::OP_SRAI;
               rvic_pkg::F3_6: result_in.operation = rvic_pkg::OP_ORI;
               default:        result_in.operation = rvic_pkg::OP_ANDI;
            endcase
         end
         rvic_pkg::OPC_OP: begin
            // funct7 bit 0 selects the multiply group by funct3 alone
            result_in.instr_class  = rvic_pkg::CL_OP;
            result_in.decode_error = rvic_pkg::ERR_NONE;
            if (f7[0]) begin
               result_in.operation = rvic_pkg::OP_MUL + {4'd0, f3};
            end else begin
               unique case (f3)
                  rvic_pkg::F3_0: result_in.operation = (f7 == rvic_pkg::F7_ZERO) ?
                                     rvic_pkg::OP_ADD : rvic_pkg::OP_SUB;
                  rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_SLL;
                  rvic_pkg::F3_2: result_in.operation = rvic_pkg::OP_SLT;
                  rvic_pkg::F3_3: result_in.operation = rvic_pkg::OP_SLTU;
                  rvic_pkg::F3_4: result_in.operation = rvic_pkg::OP_XOR;
                  rvic_pkg::F3_5: result_in.operation = (f7 == rvic_pkg::F7_ZERO) ?
                                     rvic_pkg::OP_SRL : rvic_pkg::OP_SRA;
                  rvic_pkg::F3_6: result_in.operation = rvic_pkg::OP_OR;
                  default:        result_in.operation = rvic_pkg::OP_AND;
               endcase
            end
         end
         rvic_pkg::OPC_SYSTEM: begin
            result_in.instr_class  = rvic_pkg::CL_SYSTEM;
            result_in.decode_error = rvic_pkg::ERR_NONE;
            unique case (f3)
               rvic_pkg::F3_0: begin
                  // immediate patterns take priority over funct7 patterns
                  if (imm == rvic_pkg::IMM_ECALL) begin
                     result_in.operation = rvic_pkg::OP_ECALL;
                  end else if (imm == rvic_pkg::IMM_EBREAK) begin
                     result_in.operation = rvic_pkg::OP_EBREAK;
                  end else if (imm == rvic_pkg::IMM_SRET) begin
                     result_in.operation = rvic_pkg::OP_SRET;
                  end else if (imm == rvic_pkg::IMM_WFI) begin
                     result_in.operation = rvic_pkg::OP_WFI;
                  end else if (f7 == rvic_pkg::F7_SFENCE_VMA) begin
                     result_in.operation = rvic_pkg::OP_SFENCE_VMA;
                  end else if (f7 == rvic_pkg::F7_SINVAL_VMA) begin
                     result_in.operation = rvic_pkg::OP_SINVAL_VMA;
                  end else if (f7 == rvic_pkg::F7_SFENCE_INV) begin
                     result_in.operation = (rs2 == 5'd0) ?
                        rvic_pkg::OP_SFENCE_W_INVAL : rvic_pkg::OP_SFENCE_INVAL_IR;
                  end else begin
                     result_in.operation    = rvic_pkg::OP_NONE;
                     result_in.decode_error = rvic_pkg::ERR_SUBFN;
                  end
               end
               rvic_pkg::F3_1: result_in.operation = rvic_pkg::OP_CSRRW;
               rvic_pkg::F3_2: result_in.operation = rvic_pkg::OP_CSRRS;
               rvic_pkg::F3_3: result_in.operation = rvic_pkg::OP_CSRRC;
               rvic_pkg::F3_5: result_in.operation = rvic_pkg::OP_CSRRWI;
               rvic_pkg::F3_6: result_in.operation = rvic_pkg::OP_CSRRSI;
               rvic_pkg::F3_7: result_in.operation = rvic_pkg::OP_CSRRCI;
               default: begin
                  result_in.operation    = rvic_pkg::OP_NONE;
                  result_in.decode_error = rvic_pkg::ERR_SUBFN;
               end
            endcase
         end
         rvic_pkg::OPC_LUI: begin
            result_in.instr_class  = rvic_pkg::CL_UPPER;
            result_in.operation    = rvic_pkg::OP_LUI;
            result_in.decode_error = rvic_pkg::ERR_NONE;
         end
         rvic_pkg::OPC_AUIPC: begin
            result_in.instr_class  = rvic_pkg::CL_UPPER;
            result_in.operation    = rvic_pkg::OP_AUIPC;
            result_in.decode_error = rvic_pkg::ERR_NONE;
         end
         rvic_pkg::OPC_FENCE: begin
            result_in.instr_class = rvic_pkg::CL_FENCE;
            if (f3 == rvic_pkg::F3_0) begin
               result_in.operation    = rvic_pkg::OP_MEM_FENCE;
               result_in.decode_error = rvic_pkg::ERR_NONE;
            end else if (f3 == rvic_pkg::F3_1) begin
               result_in.operation    = rvic_pkg::OP_INSTR_FENCE;
               result_in.decode_error = rvic_pkg::ERR_NONE;
            end
         end
         default: begin
            result_in.instr_class  = rvic_pkg::CL_LOAD;
            result_in.operation    = rvic_pkg::OP_NONE;
            result_in.decode_error = rvic_pkg::ERR_OPCODE;
         end
      endcase
   end

   // Drive the response port
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_instr_class  = result_ff.instr_class;
   assign rsp_operation    = result_ff.operation;
   assign rsp_decode_error = result_ff.decode_error;

   // An unknown opcode reports class and operation zero
   a_opcode_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.decode_error == rvic_pkg::ERR_OPCODE |->
         result_ff.instr_class == rvic_pkg::CL_LOAD && result_ff.operation == rvic_pkg::OP_NONE)
      else $error("opcode error with nonzero class or operation");

   // A sub-function error reports operation zero
   a_subfn_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.decode_error == rvic_pkg::ERR_SUBFN |->
         result_ff.operation == rvic_pkg::OP_NONE)
      else $error("sub-function error with nonzero operation");

   // Decoded fields stay in range
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> result_ff.instr_class <= rvic_pkg::CL_LAST &&
         result_ff.operation <= rvic_pkg::OP_INSTR_FENCE &&
         result_ff.decode_error != 2'd3)
      else $error("decoded field out of range");

   // A beat in the input stage that moves on shows up as a response
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && stage2_ready |=> rsp_valid_ff)
      else $error("input stage beat lost");

   // A waiting response never blocks an empty input stage
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_ready)
      else $error("request not ready with input stage empty");

endmodule
